/* hw/rtl/spic_pkg.sv */
// shared types and constants for the segment pair intersection counter
package spic_pkg;

  localparam int MaxSegments = 1024;
  localparam int CoordBits = 16;
  localparam int AddrBits = $clog2(MaxSegments);
  localparam int HeldBits = $clog2(MaxSegments + 1);
  localparam int CountBits = 19;
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef struct packed {
    logic signed [CoordBits-1:0] sx;
    logic signed [CoordBits-1:0] sy;
    logic signed [CoordBits-1:0] ex;
    logic signed [CoordBits-1:0] ey;
  } seg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_I,
    ST_WAIT_I,
    ST_RD_J,
    ST_WAIT_J,
    ST_TEST,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic hit;
  } test_ctl_t;

endpackage

/* hw/rtl/segment_pair_intersection_counter_top.sv */
// Segment pair intersection counter. Segments load one beat per cycle into a
// 1024-entry store. After the beat marked last, a check state tests the held count,
// then every unordered pair of the N held segments is read from the store and
// tested by one shared multiplier that forms the four orientation signs in turn.
// The input is not ready during the count phase or while the result beat waits.
// Segments beyond the store depth are dropped and flagged.
module segment_pair_intersection_counter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [spic_pkg::CoordBits-1:0] start_x,
  input  logic signed [spic_pkg::CoordBits-1:0] start_y,
  input  logic signed [spic_pkg::CoordBits-1:0] end_x,
  input  logic signed [spic_pkg::CoordBits-1:0] end_y,
  input  logic                                  last_segment,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [spic_pkg::CountBits-1:0]        pair_count,
  output logic                                  overflow
);

  localparam int AB = spic_pkg::AddrBits;
  localparam int HB = spic_pkg::HeldBits;

  spic_pkg::state_t state, state_next;
  spic_pkg::seg_t   mem [spic_pkg::MaxSegments];
  spic_pkg::seg_t   rd_data, seg_a, seg_b, wr_seg;
  logic [HB-1:0]    held;
  logic [HB-1:0]    idx_i, idx_j;
  logic [AB-1:0]    rd_addr;
  logic             ovf;
  logic [spic_pkg::CountBits-1:0] count;
  logic             test_start;
  spic_pkg::test_ctl_t tctl;

  logic acc;
  assign acc = in_valid && in_ready;
  assign in_ready = (state == spic_pkg::ST_LOAD);
  assign out_valid = (state == spic_pkg::ST_OUT);
  assign pair_count = count;
  assign overflow = ovf;

  assign wr_seg = '{sx: start_x, sy: start_y, ex: end_x, ey: end_y};

  always_ff @(posedge clk) begin
    if (acc && held < HB'(spic_pkg::MaxSegments)) mem[held[AB-1:0]] <= wr_seg;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = (state == spic_pkg::ST_RD_I) ? idx_i[AB-1:0] : idx_j[AB-1:0];
    state_next = state;
    test_start = 1'b0;
    case (state)
      spic_pkg::ST_LOAD:   if (acc && last_segment) state_next = spic_pkg::ST_DONE;
      spic_pkg::ST_DONE:   state_next = (held < HB'(2)) ? spic_pkg::ST_OUT
                                                         : spic_pkg::ST_RD_I;
      spic_pkg::ST_RD_I:   state_next = spic_pkg::ST_WAIT_I;
      spic_pkg::ST_WAIT_I: state_next = spic_pkg::ST_RD_J;
      spic_pkg::ST_RD_J:   state_next = spic_pkg::ST_WAIT_J;
      spic_pkg::ST_WAIT_J: begin
        state_next = spic_pkg::ST_TEST;
        test_start = 1'b1;
      end
      spic_pkg::ST_TEST: begin
        if (tctl.start) begin
          if (idx_j + HB'(1) < held) state_next = spic_pkg::ST_RD_J;
          else if (idx_i + HB'(2) < held) state_next = spic_pkg::ST_RD_I;
          else state_next = spic_pkg::ST_OUT;
        end
      end
      spic_pkg::ST_OUT:    if (out_ready) state_next = spic_pkg::ST_LOAD;
      default:             state_next = spic_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= spic_pkg::ST_LOAD;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= '0;
      ovf   <= 1'b0;
      count <= '0;
      idx_i <= '0;
      idx_j <= '0;
    end else begin
      case (state)
        spic_pkg::ST_LOAD: begin
          if (acc) begin
            if (held < HB'(spic_pkg::MaxSegments)) held <= held + HB'(1);
            else ovf <= 1'b1;
          end
          count <= '0;
          idx_i <= '0;
          idx_j <= HB'(1);
        end
        spic_pkg::ST_WAIT_I: seg_a <= rd_data;
        spic_pkg::ST_WAIT_J: seg_b <= rd_data;
        spic_pkg::ST_TEST: begin
          if (tctl.start) begin
            if (tctl.hit && count != spic_pkg::CountMax) count <= count + 1'b1;
            if (idx_j + HB'(1) < held) idx_j <= idx_j + HB'(1);
            else begin
              idx_i <= idx_i + HB'(1);
              idx_j <= idx_i + HB'(2);
            end
          end
        end
        spic_pkg::ST_OUT: if (out_ready) begin
          held <= '0;
          ovf  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  spic_pair_test u_test (
    .clk   (clk),
    .rst   (rst),
    .start (test_start),
    .seg_a (seg_a),
    .seg_b (seg_b),
    .ctl   (tctl)
  );

endmodule

/* hw/rtl/spic_pair_test.sv */
// sequenced pair test: four orientation signs from one shared multiplier
module spic_pair_test (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  spic_pkg::seg_t      seg_a,
  input  spic_pkg::seg_t      seg_b,
  output spic_pkg::test_ctl_t ctl
);

  localparam int DB = spic_pkg::DiffBits;
  localparam int PB = spic_pkg::ProdBits;
  localparam int CB = spic_pkg::CrossBits;

  logic        busy;
  logic [3:0]  step;
  logic [1:0]  ori;
  logic        half;
  logic signed [PB-1:0] prod_a;
  logic        done;
  logic        hit;
  logic [1:0]  sgn [4];

  spic_pkg::seg_t g;
  logic signed [spic_pkg::CoordBits-1:0] px, py;
  logic signed [DB-1:0] m1, m2;
  logic signed [PB-1:0] prod;
  logic signed [CB-1:0] crs;
  logic [1:0] s_now;
  logic       pos0, neg0;

  always_comb begin
    case (ori)
      2'd0: begin g = seg_a; px = seg_b.sx; py = seg_b.sy; end
      2'd1: begin g = seg_a; px = seg_b.ex; py = seg_b.ey; end
      2'd2: begin g = seg_b; px = seg_a.sx; py = seg_a.sy; end
      default: begin g = seg_b; px = seg_a.ex; py = seg_a.ey; end
    endcase
    if (!half) begin
      m1 = DB'(g.ex) - DB'(g.sx);
      m2 = DB'(py) - DB'(g.sy);
    end else begin
      m1 = DB'(g.ey) - DB'(g.sy);
      m2 = DB'(px) - DB'(g.sx);
    end
    prod = m1 * m2;
    crs = CB'(prod_a) - CB'(prod);
    s_now = {crs < 0, crs > 0};
  end

  function automatic logic btw(input logic signed [spic_pkg::CoordBits-1:0] x,
                               input logic signed [spic_pkg::CoordBits-1:0] a,
                               input logic signed [spic_pkg::CoordBits-1:0] b);
    btw = (x >= a && x <= b) || (x >= b && x <= a);
  endfunction

  logic box0, box1, box2, box3, proper;
  always_comb begin
    box0 = btw(seg_b.sx, seg_a.sx, seg_a.ex) && btw(seg_b.sy, seg_a.sy, seg_a.ey);
    box1 = btw(seg_b.ex, seg_a.sx, seg_a.ex) && btw(seg_b.ey, seg_a.sy, seg_a.ey);
    box2 = btw(seg_a.sx, seg_b.sx, seg_b.ex) && btw(seg_a.sy, seg_b.sy, seg_b.ey);
    box3 = btw(seg_a.ex, seg_b.sx, seg_b.ex) && btw(seg_a.ey, seg_b.sy, seg_b.ey);
    pos0 = (sgn[0] != 2'b00) && (sgn[1] != 2'b00) && (sgn[0] != sgn[1]);
    neg0 = (sgn[2] != 2'b00) && (sgn[3] != 2'b00) && (sgn[2] != sgn[3]);
    proper = pos0 && neg0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ori  <= 2'd0;
      half <= 1'b0;
      step <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        ori  <= 2'd0;
        half <= 1'b0;
        step <= 4'd0;
      end else if (busy && step == 4'd8) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (busy) begin
        half <= ~half;
        step <= step + 4'd1;
        if (half) ori <= ori + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !half && step != 4'd8) prod_a <= prod;
    if (busy && half) sgn[ori] <= s_now;
    if (busy && step == 4'd8)
      hit <= proper || (sgn[0] == 2'b00 && box0) || (sgn[1] == 2'b00 && box1) ||
             (sgn[2] == 2'b00 && box2) || (sgn[3] == 2'b00 && box3);
  end

  assign ctl.start = done;
  assign ctl.busy  = busy;
  assign ctl.hit   = hit;

endmodule

/* verif/segment_pair_intersection_counter_top_tb.sv */
// testbench for the segment pair intersection counter: random and directed segment sets
`timescale 1ns / 100ps

module segment_pair_intersection_counter_top_tb;

  localparam longint CycleLimit = 40_000_000;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic               last;
  } segment_beat_t;

  typedef struct {
    logic [spic_pkg::CountBits-1:0] count;
    logic                           ovf;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;
  logic last_segment = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [spic_pkg::CountBits-1:0] pair_count;
  logic overflow;

  segment_beat_t pending_beats[$];
  pair_result_t  expected_counts[$];
  segment_beat_t held_segs[spic_pkg::MaxSegments];
  int            held_num = 0;
  logic          dropped_seen = 1'b0;
  int            idle_phase = 0;
  bit            failed = 1'b0;
  longint        cycles = 0;

  segment_pair_intersection_counter_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .last_segment(last_segment),
    .out_valid(out_valid), .out_ready(out_ready),
    .pair_count(pair_count), .overflow(overflow)
  );

  always #4 clk = ~clk;

  function automatic int orient_sign(segment_beat_t g, longint px, longint py);
    longint v;
    v = (longint'(g.ex) - g.sx) * (py - g.sy) - (longint'(g.ey) - g.sy) * (px - g.sx);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit in_span(longint v, longint a, longint b);
    return (a < b) ? (v >= a && v <= b) : (v >= b && v <= a);
  endfunction

  function automatic bit on_box(segment_beat_t g, longint px, longint py);
    return in_span(px, g.sx, g.ex) && in_span(py, g.sy, g.ey);
  endfunction

  function automatic bit segs_meet(segment_beat_t a, segment_beat_t b);
    int d1, d2, d3, d4;
    d1 = orient_sign(a, b.sx, b.sy);
    d2 = orient_sign(a, b.ex, b.ey);
    d3 = orient_sign(b, a.sx, a.sy);
    d4 = orient_sign(b, a.ex, a.ey);
    if (d1 * d2 < 0 && d3 * d4 < 0) return 1'b1;
    if (d1 == 0 && on_box(a, b.sx, b.sy)) return 1'b1;
    if (d2 == 0 && on_box(a, b.ex, b.ey)) return 1'b1;
    if (d3 == 0 && on_box(b, a.sx, a.sy)) return 1'b1;
    if (d4 == 0 && on_box(b, a.ex, a.ey)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic store_segment(segment_beat_t b);
    longint cnt;
    pair_result_t r;
    cnt = 0;
    if (held_num < spic_pkg::MaxSegments) begin
      held_segs[held_num] = b;
      held_num++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (b.last) begin
      for (int i = 0; i < held_num; i++)
        for (int j = i + 1; j < held_num; j++)
          if (segs_meet(held_segs[i], held_segs[j])) cnt++;
      if (cnt > spic_pkg::CountMax) cnt = spic_pkg::CountMax;
      r.count = cnt[spic_pkg::CountBits-1:0];
      r.ovf = dropped_seen;
      expected_counts = {expected_counts, r};
      held_num = 0;
      dropped_seen = 1'b0;
    end
  endtask

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // segment driver
  always @(posedge clk) begin
    segment_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        b.sx = start_x; b.sy = start_y; b.ex = end_x; b.ey = end_y;
        b.last = last_segment;
        store_segment(b);
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 &&
            !roll(idle_phase == 0 ? 11 : (idle_phase == 1 ? 59 : 0))) begin
          b = pending_beats.pop_front();
          start_x <= b.sx; start_y <= b.sy; end_x <= b.ex; end_y <= b.ey;
          last_segment <= b.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pair_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $error("result beat with no expectation: pair_count %0d", pair_count);
          failed = 1'b1;
        end else begin
          e = expected_counts.pop_front();
          if (pair_count !== e.count) begin
            $error("pair_count: expected %0d, actual %0d", e.count, pair_count);
            failed = 1'b1;
          end
          if (overflow !== e.ovf) begin
            $error("overflow: expected %0d, actual %0d", e.ovf, overflow);
            failed = 1'b1;
          end
        end
      end
      out_ready <= !roll(idle_phase == 0 ? 59 : (idle_phase == 1 ? 11 : 0));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("segment_pair_intersection_counter_top_tb failed");
      $finish;
    end
  end

  task automatic push_seg(int sx, int sy, int ex, int ey, bit last);
    segment_beat_t b;
    b.sx = 16'(sx); b.sy = 16'(sy); b.ex = 16'(ex); b.ey = 16'(ey); b.last = last;
    pending_beats = {pending_beats, b};
  endtask

  function automatic int near_coord(int base);
    return base + int'($urandom_range(16)) - 8;
  endfunction

  task automatic push_random_set(int n);
    int bx, by, mode;
    mode = $urandom_range(3);
    case ($urandom_range(3))
      0: begin bx = -32760; by = 32759; end
      1: begin bx = 32759; by = -32760; end
      2: begin bx = 0; by = 0; end
      default: begin bx = $urandom_range(65000) - 32500; by = $urandom_range(65000) - 32500; end
    endcase
    for (int k = 0; k < n; k++) begin
      if (mode == 0)
        push_seg($signed(16'($urandom)), $signed(16'($urandom)),
                 $signed(16'($urandom)), $signed(16'($urandom)), k == n - 1);
      else
        push_seg(near_coord(bx), near_coord(by), near_coord(bx), near_coord(by), k == n - 1);
    end
  endtask

  task automatic wait_drained();
    wait (pending_beats.size() == 0 && !in_valid && expected_counts.size() == 0);
  endtask

  initial begin
    int n, sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes crossing, collinear containment, point on segment, touching ends
    push_seg(-32768, -32768, 32767, 32767, 0);
    push_seg(-32768, 32767, 32767, -32768, 1);
    push_seg(0, 0, 10, 0, 0);
    push_seg(2, 0, 5, 0, 0);
    push_seg(3, 0, 3, 0, 0);
    push_seg(10, 0, 10, 9, 0);
    push_seg(20, 20, 30, 30, 0);
    push_seg(-32768, 0, -32768, 0, 1);
    push_seg(7, 7, 8, 9, 1);
    push_seg(32767, 32767, 32767, -32768, 0);
    push_seg(32767, 0, 32767, 5, 0);
    push_seg(-1, -1, -1, -1, 1);
    wait_drained();

    // store full: more segments than the store holds
    for (int k = 0; k < spic_pkg::MaxSegments + 2; k++)
      push_seg(near_coord(0), near_coord(0), near_coord(0), near_coord(0),
               k == spic_pkg::MaxSegments + 1);
    wait_drained();
    push_seg(1, 1, 2, 2, 1);

    for (int ph = 0; ph < 3; ph++) begin
      idle_phase = ph;
      sent = 0;
      while (sent < 250) begin
        n = roll(5) ? $urandom_range(40, 20) : $urandom_range(12, 1);
        push_random_set(n);
        sent += n;
        wait (pending_beats.size() == 0);
        if (ph == 1 && sent > 120 && sent <= 120 + n) wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (!failed)
      $display("segment_pair_intersection_counter_top_tb passed");
    else
      $display("segment_pair_intersection_counter_top_tb failed");
    $finish;
  end

endmodule
